// File: rtl/pair_keyed_hours_table_macros.svh
// ----------------------------------------------------------------------------
// pair_keyed_hours_table_macros.svh
// Assertion macros for the hours table; empty when synthesising.
// ----------------------------------------------------------------------------
`ifndef PAIR_KEYED_HOURS_TABLE_MACROS_SVH
`define PAIR_KEYED_HOURS_TABLE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PKHT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pkht: check failed");
// next-cycle implication
`define PKHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pkht: check failed");
`else
`define PKHT_ASSERT_NOW(lbl, clk, rst_n, ante, cons)
`define PKHT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/pkht_pkg.sv
// ----------------------------------------------------------------------------
// pkht_pkg
// Shared codes, widths and control types of the hours table.
// ----------------------------------------------------------------------------
package pkht_pkg;

    localparam int FIELD_W  = 16;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 7;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_ASSIGN = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LIST   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_LISTED   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NONE     = 3'd5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINAL
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture input item, restart scan
        logic advance;  // evaluate held entry, issue next read
        logic finish;   // write back and emit final result
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_bad;     // zero owner or unknown kind on the input
        logic rd_vld;     // an entry waits in the read register
        logic hit;        // that entry matches the key
        logic is_list;    // current op is a list
        logic pend_valid; // a listed entry is held back
        logic out_free;   // output register can take an item
        logic scan_end;   // every entry evaluated
    } t_sts;

endpackage

// File: rtl/pkht_ctrl.sv
// ----------------------------------------------------------------------------
// pkht_ctrl
// Sequencer: accept, scan the table, finish the operation.
// ----------------------------------------------------------------------------
`include "pair_keyed_hours_table_macros.svh"

module pkht_ctrl
    import pkht_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   stall;

    // a list hit with an entry already held needs room at the output
    assign stall = i_sts.rd_vld & i_sts.hit & i_sts.is_list & i_sts.pend_valid
                   & ~i_sts.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_sts.in_bad ? S_FINAL : S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_end) begin
                    n_state = S_FINAL;
                end
            end
            S_FINAL: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.load    = 1'b0;
        o_cmd.advance = 1'b0;
        o_cmd.finish  = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_SCAN: begin
                o_cmd.advance = ~i_sts.scan_end & ~stall;
            end
            S_FINAL: begin
                o_cmd.finish = i_sts.out_free;
            end
            default: ;
        endcase
    end

    `PKHT_ASSERT_NEXT(a_scan_to_final, i_clk, i_rst_n,
                      (r_state == S_SCAN) && i_sts.scan_end, r_state == S_FINAL)

endmodule

// File: rtl/pkht_dp.sv
// ----------------------------------------------------------------------------
// pkht_dp
// Table storage, one-entry-per-cycle scan (held by a list stall), held list entry, output register.
// ----------------------------------------------------------------------------
`include "pair_keyed_hours_table_macros.svh"

module pkht_dp
    import pkht_pkg::*;
#(
    parameter int ENTRIES  = 64,
    parameter int KEY_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [KIND_W-1:0]   i_kind,
    input  logic [FIELD_W-1:0]  i_owner_id,
    input  logic [FIELD_W-1:0]  i_item_id,
    input  logic [FIELD_W-1:0]  i_hours,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [STATUS_W-1:0] o_status,
    output logic [FIELD_W-1:0]  o_found_item,
    output logic [FIELD_W-1:0]  o_found_hours,
    output logic [COUNT_W-1:0]  o_removed_count,
    output logic                o_last
);

    localparam int KW = (KEY_BITS < FIELD_W) ? KEY_BITS : FIELD_W;
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int WW = 2 * KW + FIELD_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);

    // table word: {hours, item, owner}
    logic [WW-1:0]      r_mem [ENTRIES];
    logic [WW-1:0]      r_rd_word;
    logic [ENTRIES-1:0] r_valid;

    // operation
    logic [KIND_W-1:0]  r_kind;
    logic [KW-1:0]      r_owner;
    logic [KW-1:0]      r_item;
    logic [FIELD_W-1:0] r_hours;
    logic               r_bad;

    // scan
    logic [IW-1:0]      r_addr;
    logic [IW-1:0]      r_idx;
    logic               r_issue_done;
    logic               r_rd_vld;
    logic               r_hit_found;
    logic [IW-1:0]      r_hit_idx;
    logic               r_free_found;
    logic [IW-1:0]      r_free_idx;
    logic [CW-1:0]      r_count;

    // held list entry
    logic               r_pend_valid;
    logic [KW-1:0]      r_pend_item;
    logic [FIELD_W-1:0] r_pend_hours;

    // output register
    logic                r_o_valid;
    logic [STATUS_W-1:0] r_o_status;
    logic [FIELD_W-1:0]  r_o_item;
    logic [FIELD_W-1:0]  r_o_hours;
    logic [COUNT_W-1:0]  r_o_count;
    logic                r_o_last;

    logic [KW-1:0]       cur_owner;
    logic [KW-1:0]       cur_item;
    logic [FIELD_W-1:0]  cur_hours;
    logic                cur_valid;
    logic                hit;
    logic                out_free;
    logic                eval;
    logic                issue;
    logic                push;
    logic [IW-1:0]       rd_addr;

    logic [STATUS_W-1:0] fin_status;
    logic [FIELD_W-1:0]  fin_item;
    logic [FIELD_W-1:0]  fin_hours;
    logic [COUNT_W-1:0]  fin_count;
    logic                fin_wr;
    logic                fin_insert;
    logic [IW-1:0]       fin_idx;

    assign cur_owner = r_rd_word[KW-1:0];
    assign cur_item  = r_rd_word[2*KW-1:KW];
    assign cur_hours = r_rd_word[WW-1:2*KW];
    assign cur_valid = r_valid[r_idx];

    assign hit = cur_valid && (cur_owner == r_owner)
                 && ((r_kind != KIND_ASSIGN) || (cur_item == r_item));

    assign out_free = ~r_o_valid | i_out_ready;
    assign eval     = i_cmd.advance & r_rd_vld;
    assign issue    = i_cmd.advance & ~r_issue_done;
    assign push     = eval & hit & (r_kind == KIND_LIST) & r_pend_valid;
    // while stalled the read register re-reads its own entry
    assign rd_addr  = issue ? r_addr : r_idx;

    assign o_sts.in_bad     = (i_owner_id[KW-1:0] == '0)
                              || ((i_kind != KIND_ASSIGN) && (i_kind != KIND_REMOVE)
                                  && (i_kind != KIND_LIST));
    assign o_sts.rd_vld     = r_rd_vld;
    assign o_sts.hit        = hit;
    assign o_sts.is_list    = (r_kind == KIND_LIST);
    assign o_sts.pend_valid = r_pend_valid;
    assign o_sts.out_free   = out_free;
    assign o_sts.scan_end   = r_issue_done & ~r_rd_vld;

    // final result of the operation
    always_comb begin
        fin_status = ST_NONE;
        fin_item   = '0;
        fin_hours  = '0;
        fin_count  = '0;
        fin_wr     = 1'b0;
        fin_insert = 1'b0;
        fin_idx    = r_free_idx;
        if (!r_bad) begin
            case (r_kind)
                KIND_ASSIGN: begin
                    if (r_hit_found) begin
                        fin_status = ST_UPDATED;
                        fin_wr     = 1'b1;
                        fin_idx    = r_hit_idx;
                    end else if (r_free_found) begin
                        fin_status = ST_INSERTED;
                        fin_wr     = 1'b1;
                        fin_insert = 1'b1;
                    end else begin
                        fin_status = ST_FULL;
                    end
                end
                KIND_REMOVE: begin
                    fin_status = ST_REMOVED;
                    fin_count  = COUNT_W'(r_count);
                end
                KIND_LIST: begin
                    if (r_pend_valid) begin
                        fin_status = ST_LISTED;
                        fin_item   = FIELD_W'(r_pend_item);
                        fin_hours  = r_pend_hours;
                    end
                end
                default: fin_status = ST_NONE;
            endcase
        end
    end

    // table memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish && fin_wr) begin
            r_mem[fin_idx] <= {r_hours, r_item, r_owner};
        end
        r_rd_word <= r_mem[rd_addr];
    end

    // occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (eval && hit && (r_kind == KIND_REMOVE)) begin
                r_valid[r_idx] <= 1'b0;
            end
            if (i_cmd.finish && fin_insert) begin
                r_valid[r_free_idx] <= 1'b1;
            end
        end
    end

    // operation and scan bookkeeping
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue_done <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_pend_valid <= 1'b0;
            r_count      <= '0;
            r_addr       <= '0;
            r_idx        <= '0;
            r_bad        <= 1'b0;
            r_kind       <= KIND_ASSIGN;
        end else if (i_cmd.load) begin
            r_kind       <= i_kind;
            r_bad        <= o_sts.in_bad;
            r_issue_done <= 1'b0;
            r_rd_vld     <= 1'b0;
            r_hit_found  <= 1'b0;
            r_free_found <= 1'b0;
            r_pend_valid <= 1'b0;
            r_count      <= '0;
            r_addr       <= '0;
        end else if (i_cmd.advance) begin
            r_rd_vld <= ~r_issue_done;
            if (issue) begin
                r_idx <= r_addr;
                if (r_addr == LAST_IDX) begin
                    r_issue_done <= 1'b1;
                end else begin
                    r_addr <= r_addr + IW'(1);
                end
            end
            if (eval) begin
                case (r_kind)
                    KIND_ASSIGN: begin
                        if (hit && !r_hit_found) begin
                            r_hit_found <= 1'b1;
                        end
                        if (!cur_valid && !r_free_found) begin
                            r_free_found <= 1'b1;
                        end
                    end
                    KIND_REMOVE: begin
                        if (hit) begin
                            r_count <= r_count + CW'(1);
                        end
                    end
                    KIND_LIST: begin
                        if (hit) begin
                            r_pend_valid <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // payload side of the scan, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_owner <= i_owner_id[KW-1:0];
            r_item  <= i_item_id[KW-1:0];
            r_hours <= i_hours;
        end
        if (eval && (r_kind == KIND_ASSIGN)) begin
            if (hit && !r_hit_found) begin
                r_hit_idx <= r_idx;
            end
            if (!cur_valid && !r_free_found) begin
                r_free_idx <= r_idx;
            end
        end
        if (eval && hit && (r_kind == KIND_LIST)) begin
            r_pend_item  <= cur_item;
            r_pend_hours <= cur_hours;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (i_cmd.finish || push) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_o_status <= fin_status;
            r_o_item   <= fin_item;
            r_o_hours  <= fin_hours;
            r_o_count  <= fin_count;
            r_o_last   <= 1'b1;
        end else if (push) begin
            // earlier entry goes out, the current one is held back
            r_o_status <= ST_LISTED;
            r_o_item   <= FIELD_W'(r_pend_item);
            r_o_hours  <= r_pend_hours;
            r_o_count  <= '0;
            r_o_last   <= 1'b0;
        end
    end

    assign o_out_valid     = r_o_valid;
    assign o_status        = r_o_status;
    assign o_found_item    = r_o_item;
    assign o_found_hours   = r_o_hours;
    assign o_removed_count = r_o_count;
    assign o_last          = r_o_last;

    `PKHT_ASSERT_NOW(a_push_has_room, i_clk, i_rst_n, push, out_free)
    `PKHT_ASSERT_NOW(a_insert_into_free, i_clk, i_rst_n,
                     i_cmd.finish && fin_insert, !r_valid[r_free_idx])
    `PKHT_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, r_kind == KIND_REMOVE,
                     r_count <= CW'(ENTRIES))

endmodule

// File: rtl/pair_keyed_hours_table.sv
// ----------------------------------------------------------------------------
// pair_keyed_hours_table
// Owner/item keyed hours table with assign, remove and list operations.
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata (low bit up)                          | side bits
//  ---------+-----+---------------------------------------------+--------------
//  s_axis   | in  | owner_id[15:0] item_id[31:16] hours[47:32]  | tuser = kind
//  m_axis   | out | status[2:0] found_item[18:3]                | tlast = last
//           |     | found_hours[34:19] removed_count[41:35]     |
//
// Every item scans all ENTRIES rows, one row per cycle unless a list stall
// holds the scan, through the single read port of the table memory: accept,
// the scan (ENTRIES reads, judging the last row, seeing the end), finish; an
// item with a zero owner or an unknown kind skips the scan.
// List stalls the scan while its output register is held; finish waits for it.
// Reset clears the per-row occupancy bits directly; no clearing pass.
// The next item is accepted while the last result still waits at m_axis.
// ----------------------------------------------------------------------------
module pair_keyed_hours_table
    import pkht_pkg::*;
#(
    parameter int ENTRIES  = 64,  // table rows, 1 to 64
    parameter int KEY_BITS = 16   // stored key bits, 8 to 32; above 16 only 16 are kept
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // owner_id, item_id, hours
    input  logic [1:0]  s_axis_tuser,  // kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // status, found_item, found_hours, removed_count
    output logic        m_axis_tlast   // last
);

    t_cmd                cmd;
    t_sts                sts;
    logic [STATUS_W-1:0] status;
    logic [FIELD_W-1:0]  found_item;
    logic [FIELD_W-1:0]  found_hours;
    logic [COUNT_W-1:0]  removed_count;

    // sequencer
    pkht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // table, scan and output register
    pkht_dp #(
        .ENTRIES  (ENTRIES),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_kind          (s_axis_tuser),
        .i_owner_id      (s_axis_tdata[15:0]),
        .i_item_id       (s_axis_tdata[31:16]),
        .i_hours         (s_axis_tdata[47:32]),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_out_ready     (m_axis_tready),
        .o_out_valid     (m_axis_tvalid),
        .o_status        (status),
        .o_found_item    (found_item),
        .o_found_hours   (found_hours),
        .o_removed_count (removed_count),
        .o_last          (m_axis_tlast)
    );

    // pack result fields, pad to whole bytes
    assign m_axis_tdata = {6'b0, removed_count, found_hours, found_item, status};

endmodule
